// ===== design/imu_complementary_tilt_filter_assert.svh =====
// Assertion macros for the tilt filter block.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset
`define IMUCTF_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("imuctf assertion failed");
// Check that a condition holds in the cycle after a trigger
`define IMUCTF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("imuctf assertion failed");
`else
`define IMUCTF_ASSERT(lbl, ck, rn, prop)
`define IMUCTF_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/imuctf_pkg.sv =====
// Shared types, constants and arithmetic helpers of the tilt filter.
// No dependencies; used by the CORDIC, datapath, controller and top-level files.
package imuctf_pkg;

    localparam int ATAN_ITER_DEF = 16;
    localparam int ATAN_ITER_MAX = 24;

    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic signed [31:0] DEG_180 = 32'sd11796480;

    // dt = ms*65 + floor((ms*536 + 500) / 1000), division by reciprocal
    localparam int DT_INT_MULT  = 65;
    localparam int DT_FRAC_MULT = 536;
    localparam int DT_HALF      = 500;
    localparam int DT_SHIFT     = 35;
    localparam logic [25:0] DT_RECIP = 26'd34359739;

    typedef enum logic [1:0] {
        REG_SMOOTH     = 2'd0,
        REG_THR_PITCH  = 2'd1,
        REG_THR_ROLL   = 2'd2,
        REG_THR_YAW    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_PITCH = 2'd0,
        AXIS_ROLL  = 2'd1,
        AXIS_YAW   = 2'd2
    } axis_t;

    typedef enum logic [2:0] {
        MUL_COMP_GYRO    = 3'd0,
        MUL_SMOOTH_BIAS  = 3'd1,
        MUL_CORR_DT      = 3'd2,
        MUL_SMOOTH_INNER = 3'd3,
        MUL_COMP_ACC     = 3'd4
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DT0,
        S_DT1,
        S_DT2,
        S_PREP,
        S_MCG,
        S_MSB,
        S_MCD,
        S_BIAS,
        S_INNER,
        S_MSI,
        S_MCA,
        S_QCA,
        S_ANGLE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     dt0;
        logic     dt1;
        logic     dt2;
        logic     prep;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mag_chk;
        logic     save_qa;
        logic     wr_bias;
        logic     wr_inner;
        logic     wr_angle;
        logic     out_load;
        axis_t    axis;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_full;
    } dp_status_t;

    // Arctangent of 2^-i in Q16.16 degrees
    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        logic signed [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'sd2949120;
                5'd1:    v = 32'sd1740967;
                5'd2:    v = 32'sd919879;
                5'd3:    v = 32'sd466945;
                5'd4:    v = 32'sd234378;
                5'd5:    v = 32'sd117304;
                5'd6:    v = 32'sd58666;
                5'd7:    v = 32'sd29335;
                5'd8:    v = 32'sd14668;
                5'd9:    v = 32'sd7334;
                5'd10:   v = 32'sd3667;
                5'd11:   v = 32'sd1833;
                5'd12:   v = 32'sd917;
                5'd13:   v = 32'sd458;
                5'd14:   v = 32'sd229;
                5'd15:   v = 32'sd115;
                5'd16:   v = 32'sd57;
                5'd17:   v = 32'sd29;
                5'd18:   v = 32'sd14;
                5'd19:   v = 32'sd7;
                5'd20:   v = 32'sd4;
                5'd21:   v = 32'sd2;
                5'd22:   v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    // Saturating signed 32-bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        begin
            s = {a[31], a} + {b[31], b};
            if (s[32] != s[31])
                return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            return s[31:0];
        end
    endfunction

    // Saturating signed 32-bit subtract
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        begin
            s = {a[31], a} - {b[31], b};
            if (s[32] != s[31])
                return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            return s[31:0];
        end
    endfunction

    // Round a Q32.32 product to Q16.16, ties up, and saturate
    function automatic logic signed [31:0] q_round(input logic signed [63:0] p);
        logic signed [63:0] r;
        begin
            r = (p + 64'sd32768) >>> 16;
            if (r > 64'sd2147483647)
                return 32'sh7fff_ffff;
            if (r < -64'sd2147483648)
                return 32'sh8000_0000;
            return r[31:0];
        end
    endfunction

endpackage

// ===== design/imuctf_if.sv =====
// Valid/ready channel interfaces for IMU samples and filtered angles.
// No dependencies.
interface imuctf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [14:0]        elapsed_ms;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    elapsed_ms, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  elapsed_ms, output ready);
endinterface

interface imuctf_angle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] yaw_angle;

    modport source (output valid, pitch_angle, roll_angle, yaw_angle, input ready);
    modport sink (input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

// ===== design/imuctf_cordic.sv =====
// Iterative vectoring CORDIC giving atan2(num, den) in Q16.16 degrees.
// Depends on imuctf_pkg (angle table).
module imuctf_cordic
    import imuctf_pkg::*;
#(
    parameter int ITER = ATAN_ITER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den,
    output logic signed [31:0] result,
    output logic               done
);

    localparam int CW = $clog2(ITER);
    localparam int XW = 36;

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [31:0]   z_reg, z_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 zero_reg, zero_next;

    logic signed [16:0]   dx, dy;
    logic signed [XW-1:0] sx, sy;

    // Fold a negative denominator into the right half plane
    always_comb
    begin
        dx = den[15] ? -17'(den) : 17'(den);
        dy = den[15] ? -17'(num) : 17'(num);
        sx = x_reg >>> cnt_reg;
        sy = y_reg >>> cnt_reg;
    end

    // Load on start, then rotate toward the x axis one step per cycle
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        if (start)
        begin
            x_next    = XW'(dx) <<< 16;
            y_next    = XW'(dy) <<< 16;
            z_next    = den[15] ? (num[15] ? -DEG_180 : DEG_180) : 32'sd0;
            cnt_next  = '0;
            busy_next = 1'b1;
            zero_next = (num == 16'sd0) && (den == 16'sd0);
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + atan_deg(5'(cnt_reg));
            end
            else
            begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - atan_deg(5'(cnt_reg));
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ITER - 1))
                busy_next = 1'b0;
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the rotation registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    assign result = zero_reg ? 32'sd0 : z_reg;
    assign done   = !busy_reg;

endmodule

// ===== design/imuctf_datapath.sv =====
// Datapath: sample registers, time step, shared multiplier, bias and angle state.
// Depends on imuctf_pkg and imuctf_cordic.
module imuctf_datapath
    import imuctf_pkg::*;
#(
    parameter int ATAN_ITERATIONS = ATAN_ITER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic signed [15:0] gyro_y,
    input  logic signed [15:0] gyro_z,
    input  logic [14:0]        elapsed_ms,
    input  logic [16:0]        smooth,
    input  logic [16:0]        comp,
    input  logic [14:0]        threshold_pitch,
    input  logic [14:0]        threshold_roll,
    input  logic [14:0]        threshold_yaw,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pitch_angle,
    output logic signed [31:0] roll_angle,
    output logic signed [31:0] yaw_angle
);

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [14:0]        ms_reg;
    logic [24:0]        dtv_reg;
    logic [21:0]        dtb_reg;
    logic [50:0]        dtp_reg;
    logic signed [31:0] dt_reg;
    logic signed [31:0] corr_reg;
    logic               upd_reg;
    logic signed [63:0] p_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] qa_reg;
    logic signed [31:0] inner_reg;
    logic signed [31:0] bias_reg [3];
    logic signed [31:0] angle_reg [3];
    logic signed [31:0] pitch_reg, roll_reg, yaw_reg;
    logic               out_valid_reg, out_valid_next;

    logic signed [15:0] gyro_sel, num_sel, den_sel;
    logic [14:0]        thr_sel;
    logic signed [31:0] g_q, bias_sel, angle_sel, acc_ang;
    logic signed [31:0] mul_a, mul_b;
    logic signed [32:0] corr_ext, corr_abs;
    logic [32:0]        mag_sum;
    logic               cordic_done;

    // Select the operands of the current axis
    always_comb
    begin
        case (cmd.axis)
            AXIS_PITCH:
            begin
                gyro_sel = gx_reg;
                num_sel  = ay_reg;
                den_sel  = az_reg;
                thr_sel  = threshold_pitch;
            end
            AXIS_ROLL:
            begin
                gyro_sel = gy_reg;
                num_sel  = ax_reg;
                den_sel  = az_reg;
                thr_sel  = threshold_roll;
            end
            default:
            begin
                gyro_sel = gz_reg;
                num_sel  = ax_reg;
                den_sel  = ay_reg;
                thr_sel  = threshold_yaw;
            end
        endcase
        bias_sel  = bias_reg[cmd.axis];
        angle_sel = angle_reg[cmd.axis];
        g_q       = {gyro_sel, 16'b0};
    end

    // Rounded magnitude of the corrected gyro rate
    always_comb
    begin
        corr_ext = 33'(corr_reg);
        corr_abs = corr_ext[32] ? -corr_ext : corr_ext;
        mag_sum  = 33'(corr_abs) + 33'd32768;
    end

    // Route the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_COMP_GYRO:
            begin
                mul_a = $signed({15'b0, comp});
                mul_b = g_q;
            end
            MUL_SMOOTH_BIAS:
            begin
                mul_a = $signed({15'b0, smooth});
                mul_b = bias_sel;
            end
            MUL_CORR_DT:
            begin
                mul_a = corr_reg;
                mul_b = dt_reg;
            end
            MUL_SMOOTH_INNER:
            begin
                mul_a = $signed({15'b0, smooth});
                mul_b = inner_reg;
            end
            default:
            begin
                mul_a = $signed({15'b0, comp});
                mul_b = acc_ang;
            end
        endcase
    end

    imuctf_cordic #(
        .ITER   (ATAN_ITERATIONS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.prep),
        .num    (num_sel),
        .den    (den_sel),
        .result (acc_ang),
        .done   (cordic_done)
    );

    // Capture the sample, build the time step, multiply and round
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
            gy_reg <= gyro_y;
            gz_reg <= gyro_z;
            ms_reg <= elapsed_ms;
        end
        if (cmd.dt0)
        begin
            dtv_reg <= 25'(ms_reg) * 25'(DT_FRAC_MULT) + 25'(DT_HALF);
            dtb_reg <= 22'(ms_reg) * 22'(DT_INT_MULT);
        end
        if (cmd.dt1)
            dtp_reg <= 51'(dtv_reg) * 51'(DT_RECIP);
        if (cmd.dt2)
            dt_reg <= $signed(32'(dtb_reg) + 32'(dtp_reg[50:DT_SHIFT]));
        if (cmd.prep)
            corr_reg <= sat_sub(g_q, bias_sel);
        if (cmd.mag_chk)
            upd_reg <= (mag_sum[32:16] < {2'b0, thr_sel});
        if (cmd.mul_en)
            p_reg <= mul_a * mul_b;
        q_reg <= q_round(p_reg);
        if (cmd.save_qa)
            qa_reg <= q_reg;
        if (cmd.wr_inner)
            inner_reg <= sat_add(angle_sel, q_reg);
        if (cmd.out_load)
        begin
            pitch_reg <= angle_reg[AXIS_PITCH];
            roll_reg  <= angle_reg[AXIS_ROLL];
            yaw_reg   <= angle_reg[AXIS_YAW];
        end
    end

    // Filter state: bias and angle per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i]  <= '0;
                angle_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wr_bias && upd_reg)
                bias_reg[cmd.axis] <= sat_add(qa_reg, q_reg);
            if (cmd.wr_angle)
                angle_reg[cmd.axis] <= sat_add(qa_reg, q_reg);
        end
    end

    // Output register: load on finish, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid          = out_valid_reg;
    assign pitch_angle        = pitch_reg;
    assign roll_angle         = roll_reg;
    assign yaw_angle          = yaw_reg;
    assign status.cordic_done = cordic_done;
    assign status.out_full    = out_valid_reg && !out_ready;

endmodule

// ===== design/imuctf_ctrl.sv =====
// Controller state machine sequencing the three axis updates per sample.
// Depends on imuctf_pkg and imu_complementary_tilt_filter_assert.svh.
`include "imu_complementary_tilt_filter_assert.svh"

module imuctf_ctrl
    import imuctf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_PITCH;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.dt0      = 1'b0;
        cmd.dt1      = 1'b0;
        cmd.dt2      = 1'b0;
        cmd.prep     = 1'b0;
        cmd.mul_en   = 1'b0;
        cmd.mul_sel  = MUL_COMP_GYRO;
        cmd.mag_chk  = 1'b0;
        cmd.save_qa  = 1'b0;
        cmd.wr_bias  = 1'b0;
        cmd.wr_inner = 1'b0;
        cmd.wr_angle = 1'b0;
        cmd.out_load = 1'b0;
        cmd.axis     = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    axis_next   = AXIS_PITCH;
                    state_next  = S_DT0;
                end
            end
            S_DT0:
            begin
                cmd.dt0    = 1'b1;
                state_next = S_DT1;
            end
            S_DT1:
            begin
                cmd.dt1    = 1'b1;
                state_next = S_DT2;
            end
            S_DT2:
            begin
                cmd.dt2    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MCG;
            end
            S_MCG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_COMP_GYRO;
                cmd.mag_chk = 1'b1;
                state_next  = S_MSB;
            end
            S_MSB:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SMOOTH_BIAS;
                state_next  = S_MCD;
            end
            S_MCD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CORR_DT;
                cmd.save_qa = 1'b1;
                state_next  = S_BIAS;
            end
            S_BIAS:
            begin
                cmd.wr_bias = 1'b1;
                state_next  = S_INNER;
            end
            S_INNER:
            begin
                cmd.wr_inner = 1'b1;
                state_next   = S_MSI;
            end
            S_MSI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SMOOTH_INNER;
                state_next  = S_MCA;
            end
            S_MCA:
            begin
                // Wait for the accelerometer angle
                if (status.cordic_done)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = MUL_COMP_ACC;
                    state_next  = S_QCA;
                end
            end
            S_QCA:
            begin
                cmd.save_qa = 1'b1;
                state_next  = S_ANGLE;
            end
            S_ANGLE:
            begin
                cmd.wr_angle = 1'b1;
                case (axis_reg)
                    AXIS_PITCH:
                    begin
                        axis_next  = AXIS_ROLL;
                        state_next = S_PREP;
                    end
                    AXIS_ROLL:
                    begin
                        axis_next  = AXIS_YAW;
                        state_next = S_PREP;
                    end
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_OUT:
            begin
                // Hold until the output register frees up
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `IMUCTF_ASSERT(a_prep_cordic_idle, clk, rst_n, !cmd.prep || status.cordic_done)
    `IMUCTF_ASSERT(a_load_out_free, clk, rst_n, !cmd.out_load || !status.out_full)
    `IMUCTF_ASSERT_NEXT(a_accept_busy, clk, rst_n, cmd.load_in, !in_ready)

endmodule

// ===== design/imu_complementary_tilt_filter.sv =====
// Top level of the complementary IMU tilt filter: APB registers and wiring.
// Depends on imuctf_pkg, imuctf_if, imuctf_datapath and imuctf_ctrl.
//
// Usage:
//   in_ch carries one six-axis sample plus elapsed milliseconds; out_ch carries
//   pitch, roll and yaw in Q16.16 degrees. Both use valid/ready; a transaction
//   completes when valid and ready are high at a rising clock edge.
//   The APB port holds smoothing_factor (0x0) and the pitch, roll and yaw
//   thresholds (0x4, 0x8, 0xC); write them only while the block is idle.
//   The block is ready for a new sample in the cycle after the result is
//   loaded, so it does not take a new sample before it has finished the
//   last one. The iterative CORDIC runs once per axis, one axis after
//   another; the shared multiplier work overlaps with it.
//   Reset clears the bias and angle estimates, the output valid and restores
//   the register defaults. If the receiver stalls, the finished result waits
//   in the output register; the next sample may be accepted meanwhile and
//   its result is held back until the output register is free.
module imu_complementary_tilt_filter
    import imuctf_pkg::*;
#(
    parameter int ATAN_ITERATIONS = ATAN_ITER_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    imuctf_sample_if.sink       in_ch,
    imuctf_angle_if.source      out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [16:0] smooth_reg;
    logic [14:0] thr_pitch_reg, thr_roll_reg, thr_yaw_reg;
    logic [16:0] smooth_eff, comp_eff;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;
    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic        in_ready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg    <= 17'd64225;
            thr_pitch_reg <= '0;
            thr_roll_reg  <= '0;
            thr_yaw_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SMOOTH:    smooth_reg    <= pwdata[16:0];
                REG_THR_PITCH: thr_pitch_reg <= pwdata[14:0];
                REG_THR_ROLL:  thr_roll_reg  <= pwdata[14:0];
                REG_THR_YAW:   thr_yaw_reg   <= pwdata[14:0];
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (cfg_idx)
            REG_SMOOTH:    prdata = 32'(smooth_reg);
            REG_THR_PITCH: prdata = 32'(thr_pitch_reg);
            REG_THR_ROLL:  prdata = 32'(thr_roll_reg);
            REG_THR_YAW:   prdata = 32'(thr_yaw_reg);
        endcase
    end

    // Clamp the blend weight to one and form its complement
    always_comb
    begin
        smooth_eff = (smooth_reg > Q_ONE) ? Q_ONE : smooth_reg;
        comp_eff   = Q_ONE - smooth_eff;
    end

    assign in_ch.ready = in_ready;

    imuctf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    imuctf_datapath #(
        .ATAN_ITERATIONS (ATAN_ITERATIONS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .accel_x         (in_ch.accel_x),
        .accel_y         (in_ch.accel_y),
        .accel_z         (in_ch.accel_z),
        .gyro_x          (in_ch.gyro_x),
        .gyro_y          (in_ch.gyro_y),
        .gyro_z          (in_ch.gyro_z),
        .elapsed_ms      (in_ch.elapsed_ms),
        .smooth          (smooth_eff),
        .comp            (comp_eff),
        .threshold_pitch (thr_pitch_reg),
        .threshold_roll  (thr_roll_reg),
        .threshold_yaw   (thr_yaw_reg),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .pitch_angle     (out_ch.pitch_angle),
        .roll_angle      (out_ch.roll_angle),
        .yaw_angle       (out_ch.yaw_angle)
    );

endmodule
